// File: sv/sat_pkg.sv
// Shared types and constants of the shelf atlas allocator.
// Used by shelf_atlas_allocator_core; no dependencies.
package sat_pkg;

   localparam int CoordW    = 13;
   localparam int AgeW      = 32;
   localparam int KeyW      = 64;
   localparam int RoundStep = 8;

   localparam logic [CoordW-1:0] ResetSize = 13'd1024;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
   localparam logic [1:0] STAT_NO_SPACE  = 2'd2;

   localparam logic REG_ATLAS_WIDTH  = 1'b0;
   localparam logic REG_ATLAS_HEIGHT = 1'b1;

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ALLOC  = 2'd1,
      OP_CLEAR  = 2'd2
   } op_type;

   typedef struct packed {
      logic [CoordW-1:0] base;
      logic [CoordW-1:0] span;
      logic [CoordW-1:0] fill;
      logic [AgeW-1:0]   age;
   } shelf_rec_type;

   typedef struct packed {
      logic [KeyW-1:0]   key;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
   } node_rec_type;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_LK_RD,
      S_LK_CHK,
      S_BS_RD,
      S_BS_CHK,
      S_AL_SCAN,
      S_AL_PICK,
      S_SPLIT,
      S_SP_RD,
      S_SP_WR,
      S_SP_HI,
      S_SP_LO,
      S_EV_SCAN,
      S_EV_INV,
      S_EV_NXT_RD,
      S_EV_NXT,
      S_RM_RD,
      S_RM_WR,
      S_EV_PRV_RD,
      S_EV_PRV,
      S_EV_WB,
      S_FREE,
      S_COMMIT,
      S_DONE
   } state_type;

endpackage

// File: sv/sat_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/shelf_atlas_allocator_core.sv
// Shelf atlas allocator: top level, control sequencer over a shelf RAM and a node RAM.
// Depends on sat_pkg and sat_ram.
// Clear and unused ops go straight to the response; lookup sweeps all MAX_ENTRIES
// node entries plus a binary search over the shelf RAM for every matching entry.
// Allocate: a shelf scan, a free-entry search over up to MAX_ENTRIES entries, plus per
// eviction a shelf scan, a MAX_ENTRIES node sweep and shelf RAM shifts; one item is
// in work at a time.
// After reset, S_INIT writes the full-height shelf before the first transfer.
module shelf_atlas_allocator_core
   import sat_pkg::*;
#(
   parameter int MAX_SHELVES = 512,
   parameter int MAX_ENTRIES = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_operation,
   input  logic [KeyW-1:0]   req_key,
   input  logic [CoordW-1:0] req_alloc_width,
   input  logic [CoordW-1:0] req_alloc_height,
   input  logic [AgeW-1:0]   req_generation,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [1:0]        rsp_status,
   output logic [CoordW-1:0] rsp_rect_x,
   output logic [CoordW-1:0] rsp_rect_y,
   output logic [CoordW-1:0] rsp_rect_w,
   output logic [CoordW-1:0] rsp_rect_h,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [CoordW-1:0] csr_wdata
);

   localparam int SIW = $clog2(MAX_SHELVES);
   localparam int SCW = $clog2(MAX_SHELVES + 1);
   localparam int NIW = $clog2(MAX_ENTRIES);
   localparam int NCW = $clog2(MAX_ENTRIES + 1);

   // memories
   logic          sh_we;
   logic [SIW-1:0] sh_waddr, sh_raddr;
   shelf_rec_type sh_wdata, sh_rdata;
   logic [$bits(shelf_rec_type)-1:0] sh_rdata_raw;
   logic          nd_we;
   logic [NIW-1:0] nd_waddr, nd_raddr;
   node_rec_type  nd_wdata, nd_rdata;
   logic [$bits(node_rec_type)-1:0] nd_rdata_raw;

   sat_ram #(.WIDTH($bits(shelf_rec_type)), .DEPTH(MAX_SHELVES)) u_shelf_ram (
      .clock   (clock),
      .wr_en   (sh_we),
      .wr_addr (sh_waddr),
      .wr_data (sh_wdata),
      .rd_addr (sh_raddr),
      .rd_data (sh_rdata_raw)
   );

   sat_ram #(.WIDTH($bits(node_rec_type)), .DEPTH(MAX_ENTRIES)) u_node_ram (
      .clock   (clock),
      .wr_en   (nd_we),
      .wr_addr (nd_waddr),
      .wr_data (nd_wdata),
      .rd_addr (nd_raddr),
      .rd_data (nd_rdata_raw)
   );

   assign sh_rdata = shelf_rec_type'(sh_rdata_raw);
   assign nd_rdata = node_rec_type'(nd_rdata_raw);

   // control state
   state_type        state_ff, state_in;
   logic [CoordW-1:0] aw_ff, aw_in, ah_ff, ah_in;
   logic [SCW-1:0]   count_ff, count_in;
   logic [MAX_ENTRIES-1:0] nvalid_ff, nvalid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // request and working registers
   logic [KeyW-1:0]   key_ff, key_in;
   logic [CoordW-1:0] w_ff, w_in, h_ff, h_in;
   logic [AgeW-1:0]   gen_ff, gen_in;
   logic [SCW-1:0]    idx_ff, idx_in, pidx_ff, pidx_in;
   logic              pend_ff, pend_in;
   logic [NCW-1:0]    nidx_ff, nidx_in;
   logic [NIW-1:0]    npidx_ff, npidx_in;
   logic              used_ok_ff, used_ok_in, emp_ok_ff, emp_ok_in;
   logic [SIW-1:0]    used_idx_ff, used_idx_in, emp_idx_ff, emp_idx_in;
   shelf_rec_type     used_rec_ff, used_rec_in, emp_rec_ff, emp_rec_in;
   logic              stale_ok_ff, stale_ok_in;
   logic [SIW-1:0]    stale_idx_ff, stale_idx_in;
   shelf_rec_type     stale_rec_ff, stale_rec_in;
   logic [AgeW-1:0]   bound_ff, bound_in;
   shelf_rec_type     cur_ff, cur_in, sel_rec_ff, sel_rec_in;
   logic [SIW-1:0]    cur_idx_ff, cur_idx_in, sel_idx_ff, sel_idx_in;
   logic [SCW-1:0]    j_ff, j_in;
   logic              rm_prev_ff, rm_prev_in;
   logic              best_ok_ff, best_ok_in;
   node_rec_type      best_ff, best_in;
   logic [CoordW-1:0] match_y_ff, match_y_in;
   logic [SCW-1:0]    lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [1:0]        res_status_ff, res_status_in;
   logic [CoordW-1:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [CoordW-1:0] res_w_ff, res_w_in, res_h_ff, res_h_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [CoordW-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic [CoordW-1:0] rsp_w_ff, rsp_w_in, rsp_h_ff, rsp_h_in;

   logic [CoordW:0]   round_h;
   logic              fits;
   logic [SCW:0]      mid_sum;
   logic [SCW-1:0]    mid_calc;
   logic [SCW-1:0]    cur_next;

   assign round_h  = ({1'b0, h_ff} & ~(CoordW+1)'(RoundStep - 1)) + (CoordW+1)'(RoundStep);
   assign fits     = ({1'b0, sh_rdata.span} >= round_h) && (sh_rdata.fill <= aw_ff) &&
                     (w_ff <= aw_ff - sh_rdata.fill);
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc = mid_sum[SCW:1];
   assign cur_next = SCW'(cur_idx_ff) + SCW'(1);

   always_comb begin
      state_in      = state_ff;
      aw_in         = aw_ff;
      ah_in         = ah_ff;
      count_in      = count_ff;
      nvalid_in     = nvalid_ff;
      rsp_valid_in  = rsp_valid_ff;
      key_in        = key_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      gen_in        = gen_ff;
      idx_in        = idx_ff;
      pidx_in       = pidx_ff;
      pend_in       = pend_ff;
      nidx_in       = nidx_ff;
      npidx_in      = npidx_ff;
      used_ok_in    = used_ok_ff;
      used_idx_in   = used_idx_ff;
      used_rec_in   = used_rec_ff;
      emp_ok_in     = emp_ok_ff;
      emp_idx_in    = emp_idx_ff;
      emp_rec_in    = emp_rec_ff;
      stale_ok_in   = stale_ok_ff;
      stale_idx_in  = stale_idx_ff;
      stale_rec_in  = stale_rec_ff;
      bound_in      = bound_ff;
      cur_in        = cur_ff;
      cur_idx_in    = cur_idx_ff;
      sel_rec_in    = sel_rec_ff;
      sel_idx_in    = sel_idx_ff;
      j_in          = j_ff;
      rm_prev_in    = rm_prev_ff;
      best_ok_in    = best_ok_ff;
      best_in       = best_ff;
      match_y_in    = match_y_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      res_status_in = res_status_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_w_in      = res_w_ff;
      res_h_in      = res_h_ff;
      rsp_status_in = rsp_status_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_w_in      = rsp_w_ff;
      rsp_h_in      = rsp_h_ff;

      sh_we    = 1'b0;
      sh_waddr = '0;
      sh_wdata = '0;
      sh_raddr = '0;
      nd_we    = 1'b0;
      nd_waddr = '0;
      nd_wdata = '0;
      nd_raddr = '0;
      req_ready = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT: begin
            sh_we         = 1'b1;
            sh_wdata.span = ah_ff;
            state_in      = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in        = req_key;
               w_in          = req_alloc_width;
               h_in          = req_alloc_height;
               gen_in        = req_generation;
               res_status_in = STAT_OK;
               res_x_in      = '0;
               res_y_in      = '0;
               res_w_in      = '0;
               res_h_in      = '0;
               state_in      = S_DONE;
               case (req_operation)
                  OP_LOOKUP: begin
                     nidx_in    = '0;
                     best_ok_in = 1'b0;
                     state_in   = S_LK_RD;
                  end
                  OP_ALLOC: begin
                     if (req_alloc_width == '0 || req_alloc_width > aw_ff) begin
                        res_status_in = STAT_NO_SPACE;
                     end else begin
                        idx_in     = '0;
                        pend_in    = 1'b0;
                        used_ok_in = 1'b0;
                        emp_ok_in  = 1'b0;
                        state_in   = S_AL_SCAN;
                     end
                  end
                  OP_CLEAR: begin
                     sh_we         = 1'b1;
                     sh_wdata.span = ah_ff;
                     count_in      = SCW'(1);
                     nvalid_in     = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LK_RD: begin
            if (nidx_ff < NCW'(MAX_ENTRIES)) begin
               nd_raddr = nidx_ff[NIW-1:0];
               state_in = S_LK_CHK;
            end else begin
               if (best_ok_ff) begin
                  res_x_in = best_ff.x;
                  res_y_in = best_ff.y;
                  res_w_in = best_ff.w;
                  res_h_in = best_ff.h;
               end else begin
                  res_status_in = STAT_NOT_FOUND;
               end
               state_in = S_DONE;
            end
         end
         S_LK_CHK: begin
            nidx_in  = nidx_ff + NCW'(1);
            state_in = S_LK_RD;
            if (nvalid_ff[nidx_ff[NIW-1:0]] && nd_rdata.key == key_ff) begin
               if (!best_ok_ff || nd_rdata.y > best_ff.y ||
                   (nd_rdata.y == best_ff.y && nd_rdata.x > best_ff.x)) begin
                  best_ok_in = 1'b1;
                  best_in    = nd_rdata;
               end
               // stamp the shelf of this entry: find it by base
               match_y_in = nd_rdata.y;
               lo_in      = '0;
               hi_in      = count_ff - SCW'(1);
               state_in   = S_BS_RD;
            end
         end
         S_BS_RD: begin
            if (lo_ff > hi_ff) begin
               state_in = S_LK_RD;
            end else begin
               sh_raddr = mid_calc[SIW-1:0];
               mid_in   = mid_calc;
               state_in = S_BS_CHK;
            end
         end
         S_BS_CHK: begin
            if (sh_rdata.base == match_y_ff) begin
               if (sh_rdata.fill != '0) begin
                  sh_we        = 1'b1;
                  sh_waddr     = mid_ff[SIW-1:0];
                  sh_wdata     = sh_rdata;
                  sh_wdata.age = gen_ff;
               end
               state_in = S_LK_RD;
            end else if (sh_rdata.base < match_y_ff) begin
               lo_in    = mid_ff + SCW'(1);
               state_in = S_BS_RD;
            end else if (mid_ff == '0) begin
               state_in = S_LK_RD;
            end else begin
               hi_in    = mid_ff - SCW'(1);
               state_in = S_BS_RD;
            end
         end
         S_AL_SCAN: begin
            if (idx_ff < count_ff) begin
               sh_raddr = idx_ff[SIW-1:0];
               pend_in  = 1'b1;
               pidx_in  = idx_ff;
               idx_in   = idx_ff + SCW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && fits) begin
               if (sh_rdata.fill != '0) begin
                  if (!used_ok_ff || sh_rdata.span < used_rec_ff.span) begin
                     used_ok_in  = 1'b1;
                     used_idx_in = pidx_ff[SIW-1:0];
                     used_rec_in = sh_rdata;
                  end
               end else begin
                  if (!emp_ok_ff || sh_rdata.span < emp_rec_ff.span) begin
                     emp_ok_in  = 1'b1;
                     emp_idx_in = pidx_ff[SIW-1:0];
                     emp_rec_in = sh_rdata;
                  end
               end
            end
            if (!pend_ff && idx_ff >= count_ff) begin
               state_in = S_AL_PICK;
            end
         end
         S_AL_PICK: begin
            if (used_ok_ff) begin
               sel_idx_in = used_idx_ff;
               sel_rec_in = used_rec_ff;
               nidx_in    = '0;
               state_in   = S_FREE;
            end else if (emp_ok_ff) begin
               cur_in     = emp_rec_ff;
               cur_idx_in = emp_idx_ff;
               state_in   = S_SPLIT;
            end else begin
               idx_in      = '0;
               pend_in     = 1'b0;
               bound_in    = gen_ff;
               stale_ok_in = 1'b0;
               state_in    = S_EV_SCAN;
            end
         end
         S_SPLIT: begin
            if ({1'b0, cur_ff.span} == round_h) begin
               sel_idx_in = cur_idx_ff;
               sel_rec_in = cur_ff;
               nidx_in    = '0;
               state_in   = S_FREE;
            end else if ({1'b0, cur_ff.span} < round_h ||
                         count_ff >= SCW'(MAX_SHELVES)) begin
               res_status_in = STAT_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               j_in     = count_ff;
               state_in = S_SP_RD;
            end
         end
         S_SP_RD: begin
            // move shelves above the split up by one, top first
            if (j_ff > cur_next) begin
               sh_raddr = SIW'(j_ff - SCW'(1));
               state_in = S_SP_WR;
            end else begin
               state_in = S_SP_HI;
            end
         end
         S_SP_WR: begin
            sh_we    = 1'b1;
            sh_waddr = j_ff[SIW-1:0];
            sh_wdata = sh_rdata;
            j_in     = j_ff - SCW'(1);
            state_in = S_SP_RD;
         end
         S_SP_HI: begin
            sh_we         = 1'b1;
            sh_waddr      = cur_next[SIW-1:0];
            sh_wdata      = cur_ff;
            sh_wdata.base = cur_ff.base + round_h[CoordW-1:0];
            sh_wdata.span = cur_ff.span - round_h[CoordW-1:0];
            count_in      = count_ff + SCW'(1);
            state_in      = S_SP_LO;
         end
         S_SP_LO: begin
            sh_we         = 1'b1;
            sh_waddr      = cur_idx_ff;
            sh_wdata.base = cur_ff.base;
            sh_wdata.span = round_h[CoordW-1:0];
            sel_idx_in    = cur_idx_ff;
            sel_rec_in    = sh_wdata;
            nidx_in       = '0;
            state_in      = S_FREE;
         end
         S_EV_SCAN: begin
            if (idx_ff < count_ff) begin
               sh_raddr = idx_ff[SIW-1:0];
               pend_in  = 1'b1;
               pidx_in  = idx_ff;
               idx_in   = idx_ff + SCW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && sh_rdata.fill != '0 && sh_rdata.age < bound_ff) begin
               stale_ok_in  = 1'b1;
               stale_idx_in = pidx_ff[SIW-1:0];
               stale_rec_in = sh_rdata;
               bound_in     = sh_rdata.age;
            end
            if (!pend_ff && idx_ff >= count_ff) begin
               if (!stale_ok_ff) begin
                  res_status_in = STAT_NO_SPACE;
                  state_in      = S_DONE;
               end else begin
                  cur_in      = stale_rec_ff;
                  cur_in.fill = '0;
                  cur_in.age  = '0;
                  cur_idx_in  = stale_idx_ff;
                  nidx_in     = '0;
                  pend_in     = 1'b0;
                  state_in    = S_EV_INV;
               end
            end
         end
         S_EV_INV: begin
            // drop every entry that sits on the evicted shelf
            if (nidx_ff < NCW'(MAX_ENTRIES)) begin
               nd_raddr = nidx_ff[NIW-1:0];
               pend_in  = 1'b1;
               npidx_in = nidx_ff[NIW-1:0];
               nidx_in  = nidx_ff + NCW'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && nd_rdata.y == cur_ff.base) begin
               nvalid_in[npidx_ff] = 1'b0;
            end
            if (!pend_ff && nidx_ff >= NCW'(MAX_ENTRIES)) begin
               state_in = S_EV_NXT_RD;
            end
         end
         S_EV_NXT_RD: begin
            if (cur_next < count_ff) begin
               sh_raddr = cur_next[SIW-1:0];
               state_in = S_EV_NXT;
            end else begin
               state_in = S_EV_PRV_RD;
            end
         end
         S_EV_NXT: begin
            if (sh_rdata.fill == '0) begin
               cur_in.span = cur_ff.span + sh_rdata.span;
               j_in        = cur_next + SCW'(1);
               rm_prev_in  = 1'b0;
               state_in    = S_RM_RD;
            end else begin
               state_in = S_EV_PRV_RD;
            end
         end
         S_RM_RD: begin
            // close the gap: move shelves from j upward down by one
            if (j_ff < count_ff) begin
               sh_raddr = j_ff[SIW-1:0];
               state_in = S_RM_WR;
            end else begin
               count_in = count_ff - SCW'(1);
               state_in = rm_prev_ff ? S_EV_WB : S_EV_PRV_RD;
            end
         end
         S_RM_WR: begin
            sh_we    = 1'b1;
            sh_waddr = SIW'(j_ff - SCW'(1));
            sh_wdata = sh_rdata;
            j_in     = j_ff + SCW'(1);
            state_in = S_RM_RD;
         end
         S_EV_PRV_RD: begin
            if (cur_idx_ff != '0) begin
               sh_raddr = cur_idx_ff - SIW'(1);
               state_in = S_EV_PRV;
            end else begin
               state_in = S_EV_WB;
            end
         end
         S_EV_PRV: begin
            if (sh_rdata.fill == '0) begin
               cur_in      = sh_rdata;
               cur_in.span = sh_rdata.span + cur_ff.span;
               j_in        = cur_next;
               cur_idx_in  = cur_idx_ff - SIW'(1);
               rm_prev_in  = 1'b1;
               state_in    = S_RM_RD;
            end else begin
               state_in = S_EV_WB;
            end
         end
         S_EV_WB: begin
            sh_we    = 1'b1;
            sh_waddr = cur_idx_ff;
            sh_wdata = cur_ff;
            if ({1'b0, cur_ff.span} >= round_h) begin
               state_in = S_SPLIT;
            end else begin
               idx_in      = '0;
               pend_in     = 1'b0;
               bound_in    = gen_ff;
               stale_ok_in = 1'b0;
               state_in    = S_EV_SCAN;
            end
         end
         S_FREE: begin
            if (nidx_ff >= NCW'(MAX_ENTRIES)) begin
               res_status_in = STAT_NO_SPACE;
               state_in      = S_DONE;
            end else if (!nvalid_ff[nidx_ff[NIW-1:0]]) begin
               state_in = S_COMMIT;
            end else begin
               nidx_in = nidx_ff + NCW'(1);
            end
         end
         S_COMMIT: begin
            nd_we        = 1'b1;
            nd_waddr     = nidx_ff[NIW-1:0];
            nd_wdata.key = key_ff;
            nd_wdata.x   = sel_rec_ff.fill;
            nd_wdata.y   = sel_rec_ff.base;
            nd_wdata.w   = w_ff;
            nd_wdata.h   = h_ff;
            nvalid_in[nidx_ff[NIW-1:0]] = 1'b1;
            sh_we         = 1'b1;
            sh_waddr      = sel_idx_ff;
            sh_wdata      = sel_rec_ff;
            sh_wdata.fill = sel_rec_ff.fill + w_ff;
            sh_wdata.age  = gen_ff;
            res_x_in      = sel_rec_ff.fill;
            res_y_in      = sel_rec_ff.base;
            res_w_in      = w_ff;
            res_h_in      = h_ff;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_x_in      = res_x_ff;
               rsp_y_in      = res_y_ff;
               rsp_w_in      = res_w_ff;
               rsp_h_in      = res_h_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // a register write resizes the atlas and clears it
      if (csr_we) begin
         if (csr_index == REG_ATLAS_WIDTH) begin
            aw_in = csr_wdata;
         end else begin
            ah_in = csr_wdata;
         end
         sh_we         = 1'b1;
         sh_waddr      = '0;
         sh_wdata      = '0;
         sh_wdata.span = (csr_index == REG_ATLAS_HEIGHT) ? csr_wdata : ah_ff;
         count_in      = SCW'(1);
         nvalid_in     = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         aw_ff        <= ResetSize;
         ah_ff        <= ResetSize;
         count_ff     <= SCW'(1);
         nvalid_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         count_ff     <= count_in;
         nvalid_ff    <= nvalid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      gen_ff        <= gen_in;
      idx_ff        <= idx_in;
      pidx_ff       <= pidx_in;
      pend_ff       <= pend_in;
      nidx_ff       <= nidx_in;
      npidx_ff      <= npidx_in;
      used_ok_ff    <= used_ok_in;
      used_idx_ff   <= used_idx_in;
      used_rec_ff   <= used_rec_in;
      emp_ok_ff     <= emp_ok_in;
      emp_idx_ff    <= emp_idx_in;
      emp_rec_ff    <= emp_rec_in;
      stale_ok_ff   <= stale_ok_in;
      stale_idx_ff  <= stale_idx_in;
      stale_rec_ff  <= stale_rec_in;
      bound_ff      <= bound_in;
      cur_ff        <= cur_in;
      cur_idx_ff    <= cur_idx_in;
      sel_rec_ff    <= sel_rec_in;
      sel_idx_ff    <= sel_idx_in;
      j_ff          <= j_in;
      rm_prev_ff    <= rm_prev_in;
      best_ok_ff    <= best_ok_in;
      best_ff       <= best_in;
      match_y_ff    <= match_y_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      res_status_ff <= res_status_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_w_ff      <= res_w_in;
      res_h_ff      <= res_h_in;
      rsp_status_ff <= rsp_status_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_w_ff      <= rsp_w_in;
      rsp_h_ff      <= rsp_h_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_rect_x = rsp_x_ff;
   assign rsp_rect_y = rsp_y_ff;
   assign rsp_rect_w = rsp_w_ff;
   assign rsp_rect_h = rsp_h_ff;

endmodule

// File: tb/sv/shelf_atlas_allocator_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for shelf_atlas_allocator_core: random and directed requests,
// CSR size changes and a shelf/LRU predictor. Depends on sat_pkg and the core RTL.

module shelf_atlas_allocator_core_tb;
   import sat_pkg::*;

   localparam int NumShelves = 512;
   localparam int NumNodes   = 256;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CycleLimit = 6000000;

   typedef struct {
      logic [1:0]        status;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [CoordW-1:0] w;
      logic [CoordW-1:0] h;
   } rect_rsp_type;

   class atlas_scoreboard;
      int unsigned atlas_w, atlas_h;
      int unsigned sh_base[NumShelves], sh_span[NumShelves];
      int unsigned sh_fill[NumShelves], sh_age[NumShelves];
      int          sh_count;
      bit          nd_valid[NumNodes];
      logic [63:0] nd_key[NumNodes];
      int unsigned nd_x[NumNodes], nd_y[NumNodes], nd_w[NumNodes], nd_h[NumNodes];
      rect_rsp_type pending_rects[$];
      int mismatches, n_found, n_missing, n_placed, n_full;

      function void reset_all();
         atlas_w = 1024;
         atlas_h = 1024;
         clear_atlas();
      endfunction

      function void clear_atlas();
         for (int i = 0; i < NumShelves; i++) begin
            sh_base[i] = 0; sh_span[i] = 0; sh_fill[i] = 0; sh_age[i] = 0;
         end
         for (int k = 0; k < NumNodes; k++) nd_valid[k] = 0;
         sh_span[0] = atlas_h;
         sh_count = 1;
      endfunction

      function void write_reg(logic idx, logic [CoordW-1:0] val);
         if (idx == REG_ATLAS_WIDTH) atlas_w = 32'(val);
         else atlas_h = 32'(val);
         clear_atlas();
      endfunction

      function void drop_shelf(int i);
         for (int j = i; j < sh_count - 1; j++) begin
            sh_base[j] = sh_base[j+1]; sh_span[j] = sh_span[j+1];
            sh_fill[j] = sh_fill[j+1]; sh_age[j] = sh_age[j+1];
         end
         sh_count--;
      endfunction

      // cut the lower rows of an empty shelf into a new shelf
      function int cut_shelf(int i, int unsigned rows);
         if (sh_span[i] == rows) return i;
         if (sh_span[i] < rows || sh_count >= NumShelves) return -1;
         for (int j = sh_count; j > i; j--) begin
            sh_base[j] = sh_base[j-1]; sh_span[j] = sh_span[j-1];
            sh_fill[j] = sh_fill[j-1]; sh_age[j] = sh_age[j-1];
         end
         sh_count++;
         sh_span[i] = rows; sh_fill[i] = 0; sh_age[i] = 0;
         sh_base[i+1] += rows;
         sh_span[i+1] -= rows;
         return i;
      endfunction

      function int evict_shelf(int i);
         for (int k = 0; k < NumNodes; k++)
            if (nd_valid[k] && nd_y[k] == sh_base[i]) nd_valid[k] = 0;
         sh_fill[i] = 0;
         sh_age[i] = 0;
         if (i + 1 < sh_count && sh_fill[i+1] == 0) begin
            sh_span[i] += sh_span[i+1];
            drop_shelf(i + 1);
         end
         if (i > 0 && sh_fill[i-1] == 0) begin
            sh_span[i-1] += sh_span[i];
            drop_shelf(i);
            i--;
         end
         return i;
      endfunction

      function int evict_for(int unsigned rows, int unsigned gen);
         int stale;
         int unsigned bound;
         forever begin
            stale = -1;
            bound = gen;
            for (int i = 0; i < sh_count; i++)
               if (sh_fill[i] > 0 && sh_age[i] < bound) begin
                  stale = i;
                  bound = sh_age[i];
               end
            if (stale < 0) return -1;
            stale = evict_shelf(stale);
            if (sh_span[stale] >= rows) return cut_shelf(stale, rows);
         end
      endfunction

      function rect_rsp_type find_key(logic [63:0] key, int unsigned gen);
         rect_rsp_type r;
         int best;
         r = '{STAT_NOT_FOUND, 0, 0, 0, 0};
         best = -1;
         for (int k = 0; k < NumNodes; k++) begin
            if (!nd_valid[k] || nd_key[k] != key) continue;
            for (int i = 0; i < sh_count; i++)
               if (sh_fill[i] > 0 && sh_base[i] == nd_y[k]) sh_age[i] = gen;
            if (best < 0 || nd_y[k] > nd_y[best] ||
                (nd_y[k] == nd_y[best] && nd_x[k] > nd_x[best]))
               best = k;
         end
         if (best >= 0)
            r = '{STAT_OK, CoordW'(nd_x[best]), CoordW'(nd_y[best]),
                  CoordW'(nd_w[best]), CoordW'(nd_h[best])};
         return r;
      endfunction

      function rect_rsp_type place_rect(logic [63:0] key, int unsigned w, int unsigned h,
                                        int unsigned gen);
         rect_rsp_type r;
         int unsigned rows;
         int used, empty, sel, k;
         r = '{STAT_NO_SPACE, 0, 0, 0, 0};
         rows = h - h % RoundStep + RoundStep;
         used = -1;
         empty = -1;
         if (w == 0 || w > atlas_w) return r;
         for (int i = 0; i < sh_count; i++) begin
            if (!(rows <= sh_span[i] && sh_fill[i] <= atlas_w && w <= atlas_w - sh_fill[i]))
               continue;
            if (sh_fill[i] > 0) begin
               if (used < 0 || sh_span[i] < sh_span[used]) used = i;
            end else if (empty < 0 || sh_span[i] < sh_span[empty]) begin
               empty = i;
            end
         end
         if (used >= 0) sel = used;
         else if (empty >= 0) sel = cut_shelf(empty, rows);
         else sel = evict_for(rows, gen);
         if (sel < 0) return r;
         for (k = 0; k < NumNodes && nd_valid[k]; k++) ;
         if (k >= NumNodes) return r;
         nd_valid[k] = 1;
         nd_key[k] = key;
         nd_x[k] = sh_fill[sel];
         nd_y[k] = sh_base[sel];
         nd_w[k] = w;
         nd_h[k] = h;
         sh_age[sel] = gen;
         sh_fill[sel] += w;
         r = '{STAT_OK, CoordW'(nd_x[k]), CoordW'(nd_y[k]), CoordW'(w), CoordW'(h)};
         return r;
      endfunction

      function void note_request(logic [1:0] op, logic [63:0] key, logic [CoordW-1:0] w,
                                 logic [CoordW-1:0] h, logic [AgeW-1:0] gen);
         rect_rsp_type r;
         r = '{STAT_OK, 0, 0, 0, 0};
         if (op == OP_LOOKUP) r = find_key(key, gen);
         else if (op == OP_ALLOC) r = place_rect(key, 32'(w), 32'(h), gen);
         else if (op == OP_CLEAR) clear_atlas();
         pending_rects.push_back(r);
      endfunction

      function void check_response(rect_rsp_type got);
         rect_rsp_type want;
         if (pending_rects.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response, status %0d", got.status);
            return;
         end
         want = pending_rects.pop_front();
         if (got.status == STAT_OK) n_found++;
         else if (got.status == STAT_NOT_FOUND) n_missing++;
         else n_full++;
         if (got.status != want.status || got.x != want.x || got.y != want.y ||
             got.w != want.w || got.h != want.h) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected st=%0d x=%0d y=%0d w=%0d h=%0d, ",
                         "got st=%0d x=%0d y=%0d w=%0d h=%0d"},
                        want.status, want.x, want.y, want.w, want.h,
                        got.status, got.x, got.y, got.w, got.h);
         end
      endfunction
   endclass

   logic              clock = 0;
   logic              reset = 1;
   logic              req_valid = 0;
   logic              req_ready;
   logic [1:0]        req_operation = 0;
   logic [KeyW-1:0]   req_key = 0;
   logic [CoordW-1:0] req_alloc_width = 0;
   logic [CoordW-1:0] req_alloc_height = 0;
   logic [AgeW-1:0]   req_generation = 0;
   logic              rsp_valid;
   logic              rsp_ready = 0;
   logic [1:0]        rsp_status;
   logic [CoordW-1:0] rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h;
   logic              csr_we = 0;
   logic              csr_index = 0;
   logic [CoordW-1:0] csr_wdata = 0;

   atlas_scoreboard sb = new();
   logic [63:0] stored_keys[$];
   int unsigned frame_gen;
   int unsigned cur_w, cur_h;
   bit no_stall;
   int sent_count, cfg_count;
   longint cycle_count;

   shelf_atlas_allocator_core dut (.*);

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** shelf_atlas_allocator_core: FAILED **");
         $finish;
      end
   end

   // result side: random ready stalls, check every transfer
   initial begin
      int gap;
      @(negedge reset);
      forever begin
         gap = no_stall ? 0 : $urandom_range(0, 3);
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response('{rsp_status, rsp_rect_x, rsp_rect_y, rsp_rect_w, rsp_rect_h});
      end
   end

   task automatic send_req(logic [1:0] op, logic [63:0] key, logic [CoordW-1:0] w,
                           logic [CoordW-1:0] h, logic [AgeW-1:0] gen);
      int gap;
      gap = no_stall ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_operation <= op;
      req_key <= key;
      req_alloc_width <= w;
      req_alloc_height <= h;
      req_generation <= gen;
      do @(posedge clock); while (!req_ready);
      sb.note_request(op, key, w, h, gen);
      if (op == OP_ALLOC) stored_keys.push_back(key);
      sent_count++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending_rects.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_size(int unsigned w, int unsigned h);
      drain();
      csr_we <= 1;
      csr_index <= REG_ATLAS_WIDTH;
      csr_wdata <= CoordW'(w);
      @(posedge clock);
      sb.write_reg(REG_ATLAS_WIDTH, CoordW'(w));
      csr_index <= REG_ATLAS_HEIGHT;
      csr_wdata <= CoordW'(h);
      @(posedge clock);
      sb.write_reg(REG_ATLAS_HEIGHT, CoordW'(h));
      csr_we <= 0;
      @(posedge clock);
      cur_w = w;
      cur_h = h;
      cfg_count++;
   endtask

   function automatic logic [63:0] pick_key();
      if (stored_keys.size() > 0 && $urandom_range(0, 9) < 7)
         return stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(int n_items);
      int sel;
      int unsigned w, h, gen;
      for (int n = 0; n < n_items; n++) begin
         if (n % 40 == 0) no_stall = ($urandom_range(0, 3) == 0);
         frame_gen += $urandom_range(0, 2);
         gen = ($urandom_range(0, 29) == 0) ? $urandom : frame_gen;
         sel = $urandom_range(0, 99);
         w = $urandom_range(1, (cur_w > 2) ? cur_w / 2 : 1);
         h = $urandom_range(1, (cur_h / 4 > 64) ? 64 : ((cur_h > 32) ? cur_h / 4 : 7));
         if (sel < 48)
            send_req(OP_ALLOC, {$urandom, $urandom}, CoordW'(w), CoordW'(h), gen);
         else if (sel < 88)
            send_req(OP_LOOKUP, pick_key(), CoordW'($urandom), CoordW'($urandom), gen);
         else if (sel < 91)
            send_req(OP_CLEAR, {$urandom, $urandom}, CoordW'($urandom),
                     CoordW'($urandom), gen);
         else if (sel < 93)
            send_req(OP_UNUSED, {$urandom, $urandom}, CoordW'($urandom),
                     CoordW'($urandom), gen);
         else
            send_req(OP_ALLOC, {$urandom, $urandom}, CoordW'($urandom),
                     CoordW'($urandom), gen);
      end
   endtask

   initial begin
      logic [63:0] k;
      sb.reset_all();
      cur_w = 1024;
      cur_h = 1024;
      frame_gen = 10;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corner cases
      send_req(OP_LOOKUP, 64'h0, 0, 0, 0);
      send_req(OP_ALLOC, 64'h1, 0, 5, 1);
      send_req(OP_ALLOC, 64'h2, 1025, 5, 1);
      send_req(OP_ALLOC, 64'h3, 1024, 4096, 1);
      send_req(OP_ALLOC, '1, 1, 1, 2);
      send_req(OP_ALLOC, 64'h5, 1024, 7, 2);
      k = 64'hA5A5_5A5A_F00D_0001;
      send_req(OP_ALLOC, k, 100, 8, 3);
      send_req(OP_ALLOC, k, 200, 8, 3);
      send_req(OP_LOOKUP, k, 0, 0, 4);
      send_req(OP_LOOKUP, '1, '1, '1, '1);
      send_req(OP_UNUSED, '1, '1, '1, '1);
      send_req(OP_ALLOC, 64'h6, 8191, 8191, 5);
      send_req(OP_ALLOC, 64'h7, 1000, 1000, 5);
      send_req(OP_ALLOC, 64'h8, 1000, 1000, 6);  // forces eviction
      send_req(OP_ALLOC, 64'h9, 1000, 1000, 6);  // nothing older to evict
      send_req(OP_LOOKUP, k, 0, 0, 7);
      send_req(OP_CLEAR, 0, 0, 0, 7);
      send_req(OP_LOOKUP, k, 0, 0, 7);
      send_req(OP_ALLOC, 64'hA, 1024, 1, 32'hFFFF_FFFF);
      random_phase(110);

      set_size(8, 8);
      send_req(OP_ALLOC, 64'hB, 8, 7, 1);
      send_req(OP_ALLOC, 64'hC, 8, 8, 1);
      random_phase(40);

      // fill the node table on a wide atlas; no eviction at equal generation
      set_size(4096, 4096);
      send_req(OP_ALLOC, 64'hD, 4096, 4095, 1);
      send_req(OP_CLEAR, 0, 0, 0, 1);
      frame_gen = 50;
      for (int n = 0; n < 262; n++)
         send_req(OP_ALLOC, {$urandom, $urandom}, CoordW'($urandom_range(1, 15)),
                  CoordW'($urandom_range(1, 7)), frame_gen);
      random_phase(20);

      set_size(64, 128);
      random_phase(70);
      set_size(256, 32);
      random_phase(60);

      drain();
      $display("%0d requests over %0d atlas sizes: %0d ok, %0d not found, %0d no space",
               sent_count, cfg_count + 1, sb.n_found, sb.n_missing, sb.n_full);
      $display("%0d mismatches in %0d cycles", sb.mismatches, cycle_count);
      if (sb.mismatches == 0)
         $display("** shelf_atlas_allocator_core: PASSED **");
      else
         $display("** shelf_atlas_allocator_core: FAILED **");
      $finish;
   end

   initial cycle_count = 0;

endmodule
